// File: rtl/csdm_pkg.sv
// Shared types, constants and the arctangent table of the square-to-disk mapper.
`timescale 1ns / 1ps
package csdm_pkg;

  // Fraction bits of the internal angle and CORDIC datapath
  localparam int WB = 30;
  // Quotient width: ratio is at most 1.0 in Q.30
  localparam int QW = WB + 1;
  // CORDIC x/y width and angle width
  localparam int CW = 33;
  localparam int ZW = 32;

  localparam logic [29:0] PI4_Q30  = 30'd843314857;
  localparam logic [29:0] INVK_Q30 = 30'd652032874;

  typedef enum logic [1:0] {
    SEC_1 = 2'd0,
    SEC_2 = 2'd1,
    SEC_3 = 2'd2,
    SEC_4 = 2'd3
  } csdm_sector_e;

  typedef struct packed {
    csdm_sector_e sector;
    logic         neg;
    logic         origin;
  } csdm_side_t;

  // Rotation angle of step i, atan(2^-i) in Q.30
  function automatic logic signed [ZW-1:0] atan_q30(input int i);
    logic signed [ZW-1:0] v;
    begin
      unique case (i)
        0:       v = 32'sd843314857;
        1:       v = 32'sd497837829;
        2:       v = 32'sd263043837;
        3:       v = 32'sd133525159;
        4:       v = 32'sd67021687;
        5:       v = 32'sd33543516;
        6:       v = 32'sd16775851;
        7:       v = 32'sd8388437;
        8:       v = 32'sd4194283;
        9:       v = 32'sd2097149;
        10:      v = 32'sd1048576;
        default: v = (i < WB) ? (32'sd1 <<< (WB - i)) : 32'sd0;
      endcase
      return v;
    end
  endfunction

endpackage

// File: rtl/csdm_div_cell.sv
// One restoring-division cell: decides one quotient bit and passes the word on.
`timescale 1ns / 1ps
module csdm_div_cell
  import csdm_pkg::*;
#(
  parameter int RW  = 18,
  parameter int BIT = 30
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  input  logic [RW-1:0]    rem_i,
  input  logic [RW-2:0]    den_i,
  input  logic [QW-1:0]    q_i,
  input  csdm_side_t       side_i,
  output logic             valid_o,
  output logic [RW-1:0]    rem_o,
  output logic [RW-2:0]    den_o,
  output logic [QW-1:0]    q_o,
  output csdm_side_t       side_o
);

  logic          valid_q;
  logic [RW-1:0] rem_d, rem_q, diff;
  logic [RW-2:0] den_q;
  logic [QW-1:0] q_d, q_q;
  csdm_side_t    side_q;
  logic          ge;

  // Compare, subtract when it fits, shift for the next bit
  always_comb begin
    ge    = rem_i >= {1'b0, den_i};
    diff  = rem_i - {1'b0, den_i};
    rem_d = ge ? (diff << 1) : (rem_i << 1);
    q_d   = q_i;
    q_d[BIT] = ge;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    den_q  <= den_i;
    q_q    <= q_d;
    side_q <= side_i;
  end

  assign valid_o = valid_q;
  assign rem_o   = rem_q;
  assign den_o   = den_q;
  assign q_o     = q_q;
  assign side_o  = side_q;

endmodule

// File: rtl/csdm_cordic_cell.sv
// One CORDIC rotation cell with a fixed shift and a fixed arctangent step.
`timescale 1ns / 1ps
module csdm_cordic_cell
  import csdm_pkg::*;
#(
  parameter int STEP = 0
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  input  logic signed [CW-1:0] x_i,
  input  logic signed [CW-1:0] y_i,
  input  logic signed [ZW-1:0] z_i,
  input  csdm_side_t           side_i,
  output logic                 valid_o,
  output logic signed [CW-1:0] x_o,
  output logic signed [CW-1:0] y_o,
  output logic signed [ZW-1:0] z_o,
  output csdm_side_t           side_o
);

  localparam logic signed [ZW-1:0] ATAN = atan_q30(STEP);

  logic                 valid_q;
  logic signed [CW-1:0] x_d, y_d, x_q, y_q, dx, dy;
  logic signed [ZW-1:0] z_d, z_q;
  csdm_side_t           side_q;

  // Rotate toward zero residual angle
  always_comb begin
    dx = y_i >>> STEP;
    dy = x_i >>> STEP;
    if (z_i >= 0) begin
      x_d = x_i - dx;
      y_d = y_i + dy;
      z_d = z_i - ATAN;
    end else begin
      x_d = x_i + dx;
      y_d = y_i - dy;
      z_d = z_i + ATAN;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q    <= x_d;
    y_q    <= y_d;
    z_q    <= z_d;
    side_q <= side_i;
  end

  assign valid_o = valid_q;
  assign x_o     = x_q;
  assign y_o     = y_q;
  assign z_o     = z_q;
  assign side_o  = side_q;

endmodule

// File: rtl/concentric_square_to_disk_map.sv
// Top level: concentric mapping of unit-square samples onto the unit disk.
//
// Usage:
//   Drive square_u_i / square_v_i (unsigned Q0.IN_FRAC_BITS) and pulse start.
//   A word is taken at every rising edge with start high and busy low; busy
//   is always low, so a new word may enter in every cycle.
//   Each word gives exactly one result on disk_x_o / disk_y_o (signed,
//   2^OUT_FRAC_BITS means 1.0), shown for one cycle with valid_o high.
//   The path has one input stage, 31 divider
//   cells (one quotient bit each), one multiply stage, one CORDIC cell per
//   rotation step and one output stage. Throughput is one word per cycle,
//   set by the fully pipelined cell chains.
//   The receiver cannot stall; results must be taken when valid_o is high.
//   Reset clears all valid flags, so no stale result appears afterwards.
`timescale 1ns / 1ps
module concentric_square_to_disk_map
  import csdm_pkg::*;
#(
  parameter int IN_FRAC_BITS    = 16,
  parameter int OUT_FRAC_BITS   = 14,
  parameter int ROTATION_STAGES = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [15:0] square_u_i,
  input  logic [15:0] square_v_i,
  output logic        valid_o,
  output logic signed [15:0] disk_x_o,
  output logic signed [15:0] disk_y_o
);

  localparam int F   = IN_FRAC_BITS;
  localparam int EW  = (F > 16) ? F : 16;
  localparam int AW  = F + 3;
  localparam int RW  = F + 2;
  localparam int DW  = F + 1;
  localparam int NDIV = QW;
  localparam int SH  = WB - OUT_FRAC_BITS;
  localparam int OW  = CW + 2;
  localparam int LIMHV = (OUT_FRAC_BITS > 14) ? 32767 : (1 << OUT_FRAC_BITS);
  localparam int LIMLV = (OUT_FRAC_BITS > 14) ? -32768 : -(1 << OUT_FRAC_BITS);
  localparam logic [EW-1:0] MAXIN = EW'((64'd1 << F) - 64'd1);
  localparam logic signed [AW-1:0] ONE_IN = AW'(64'd1 << F);
  localparam logic signed [OW-1:0] LIM_HI = OW'(LIMHV);
  localparam logic signed [OW-1:0] LIM_LO = OW'(LIMLV);
  localparam logic signed [OW-1:0] RND = OW'(64'd1 << (SH - 1));

  assign busy = 1'b0;

  // ---------------- input stage ----------------
  logic [EW-1:0]        u_ext, v_ext;
  logic signed [AW-1:0] a, b;
  logic [DW-1:0]        an_d, ad_d;
  csdm_side_t           side_d;

  logic                 in_valid_q;
  logic [DW-1:0]        an_q, ad_q;
  csdm_side_t           in_side_q;

  // Saturate, recenter and pick the sector
  always_comb begin
    u_ext = EW'(square_u_i);
    v_ext = EW'(square_v_i);
    if (u_ext > MAXIN) u_ext = MAXIN;
    if (v_ext > MAXIN) v_ext = MAXIN;
    a = ($signed(AW'(u_ext)) <<< 1) - ONE_IN;
    b = ($signed(AW'(v_ext)) <<< 1) - ONE_IN;
    side_d.origin = (a == 0) && (b == 0);
    if (a > -b) begin
      if (a > b) begin
        side_d.sector = SEC_1;
        an_d = DW'(b < 0 ? -b : b);
        ad_d = DW'(a);
        side_d.neg = b < 0;
      end else begin
        side_d.sector = SEC_2;
        an_d = DW'(a < 0 ? -a : a);
        ad_d = DW'(b);
        side_d.neg = a > 0;
      end
    end else begin
      if (a < b) begin
        side_d.sector = SEC_3;
        an_d = DW'(b < 0 ? -b : b);
        ad_d = DW'(-a);
        side_d.neg = !(b < 0);
      end else begin
        side_d.sector = SEC_4;
        an_d = DW'(a < 0 ? -a : a);
        ad_d = DW'(-b);
        side_d.neg = !(a > 0);
      end
    end
    // Keep the divider away from a zero divisor at the origin
    if (side_d.origin) ad_d = DW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= start && !busy;
    end
  end

  always_ff @(posedge clk_i) begin
    an_q      <= an_d;
    ad_q      <= ad_d;
    in_side_q <= side_d;
  end

  // ---------------- divider chain ----------------
  logic          dv [NDIV+1];
  logic [RW-1:0] drem [NDIV+1];
  logic [DW-1:0] dden [NDIV+1];
  logic [QW-1:0] dq [NDIV+1];
  csdm_side_t    dside [NDIV+1];

  assign dv[0]    = in_valid_q;
  assign drem[0]  = RW'(an_q);
  assign dden[0]  = ad_q;
  assign dq[0]    = '0;
  assign dside[0] = in_side_q;

  for (genvar k = 0; k < NDIV; k++) begin : g_div
    csdm_div_cell #(
      .RW  (RW),
      .BIT (NDIV - 1 - k)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (dv[k]),
      .rem_i   (drem[k]),
      .den_i   (dden[k]),
      .q_i     (dq[k]),
      .side_i  (dside[k]),
      .valid_o (dv[k+1]),
      .rem_o   (drem[k+1]),
      .den_o   (dden[k+1]),
      .q_o     (dq[k+1]),
      .side_o  (dside[k+1])
    );
  end

  // ---------------- angle and start vector ----------------
  logic [61:0]          ang_prod, x0_prod;
  logic [QW-1:0]        ang;
  logic [QW-1:0]        r_sh;
  logic signed [ZW-1:0] z0_d;
  logic signed [CW-1:0] x0_d;

  logic                 m_valid_q;
  logic signed [ZW-1:0] z0_q;
  logic signed [CW-1:0] x0_q;
  csdm_side_t           m_side_q;

  // Scale ratio by pi/4 and prescale radius by the inverse CORDIC gain
  always_comb begin
    ang_prod = 62'(dq[NDIV]) * 62'(PI4_Q30) + (62'd1 << 29);
    ang      = ang_prod[60:30];
    z0_d     = dside[NDIV].neg ? -$signed(ZW'(ang)) : $signed(ZW'(ang));
    r_sh     = QW'(dden[NDIV]) << (WB - F);
    x0_prod  = 62'(r_sh) * 62'(INVK_Q30) + (62'd1 << 29);
    x0_d     = $signed(CW'(x0_prod[60:30]));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else begin
      m_valid_q <= dv[NDIV];
    end
  end

  always_ff @(posedge clk_i) begin
    z0_q     <= z0_d;
    x0_q     <= x0_d;
    m_side_q <= dside[NDIV];
  end

  // ---------------- CORDIC chain ----------------
  logic                 cv [ROTATION_STAGES+1];
  logic signed [CW-1:0] cx [ROTATION_STAGES+1];
  logic signed [CW-1:0] cy [ROTATION_STAGES+1];
  logic signed [ZW-1:0] cz [ROTATION_STAGES+1];
  csdm_side_t           cside [ROTATION_STAGES+1];

  assign cv[0]    = m_valid_q;
  assign cx[0]    = x0_q;
  assign cy[0]    = '0;
  assign cz[0]    = z0_q;
  assign cside[0] = m_side_q;

  for (genvar i = 0; i < ROTATION_STAGES; i++) begin : g_rot
    csdm_cordic_cell #(
      .STEP (i)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (cv[i]),
      .x_i     (cx[i]),
      .y_i     (cy[i]),
      .z_i     (cz[i]),
      .side_i  (cside[i]),
      .valid_o (cv[i+1]),
      .x_o     (cx[i+1]),
      .y_o     (cy[i+1]),
      .z_o     (cz[i+1]),
      .side_o  (cside[i+1])
    );
  end

  // ---------------- output stage ----------------
  function automatic logic [15:0] to_out(input logic signed [OW-1:0] v);
    logic signed [OW-1:0] q;
    begin
      q = (v + RND) >>> SH;
      if (q > LIM_HI) q = LIM_HI;
      if (q < LIM_LO) q = LIM_LO;
      return q[15:0];
    end
  endfunction

  logic signed [OW-1:0] c_w, s_w;
  logic [15:0]          ox_d, oy_d;
  logic                 o_valid_q;
  logic [15:0]          ox_q, oy_q;

  // Rotate the result back into its sector, round and clamp; the origin maps to zero
  always_comb begin
    c_w = OW'(cx[ROTATION_STAGES]);
    s_w = OW'(cy[ROTATION_STAGES]);
    unique case (cside[ROTATION_STAGES].sector)
      SEC_1: begin
        ox_d = to_out(c_w);
        oy_d = to_out(s_w);
      end
      SEC_2: begin
        ox_d = to_out(-s_w);
        oy_d = to_out(c_w);
      end
      SEC_3: begin
        ox_d = to_out(-c_w);
        oy_d = to_out(-s_w);
      end
      default: begin
        ox_d = to_out(s_w);
        oy_d = to_out(-c_w);
      end
    endcase
    if (cside[ROTATION_STAGES].origin) begin
      ox_d = '0;
      oy_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      o_valid_q <= 1'b0;
    end else begin
      o_valid_q <= cv[ROTATION_STAGES];
    end
  end

  always_ff @(posedge clk_i) begin
    ox_q <= ox_d;
    oy_q <= oy_d;
  end

  assign valid_o  = o_valid_q;
  assign disk_x_o = $signed(ox_q);
  assign disk_y_o = $signed(oy_q);

endmodule
